>>> rtl/core/biquad_iir_saturated_top_assert.svh
// Assertion macros for the biquad filter block.
// Clocked on clk_i, disabled while rst_ni is low; needs no package.
`ifndef BIQUAD_IIR_SATURATED_TOP_ASSERT_SVH
`define BIQUAD_IIR_SATURATED_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// pre holds -> post holds in the same cycle
`define BIQ_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: implication check failed");

// pre holds -> post holds in the next cycle
`define BIQ_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`else

`define BIQ_ASSERT_IMP(name, pre, post)
`define BIQ_ASSERT_NEXT(name, pre, post)

`endif

`endif

>>> rtl/core/biq_pkg.sv
// Shared types and constants of the biquad filter block.
// Used by biq_cfg, biq_ctrl, biq_dp and the top level; no dependencies.
package biq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COEFF_WIDTH_DEF  = 32;
  localparam int COEFF_INT        = 4;   // integer bits of a coefficient
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0      = 3'd0,
    REG_B1      = 3'd1,
    REG_B2      = 3'd2,
    REG_A1      = 3'd3,
    REG_A2      = 3'd4,
    REG_OUT_MAX = 3'd5,
    REG_OUT_MIN = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_X_B0 = 3'd0,
    MUL_X_B1 = 3'd1,
    MUL_Y_A1 = 3'd2,
    MUL_X_B2 = 3'd3,
    MUL_Y_A2 = 3'd4
  } mul_sel_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_Y      = 3'd1,  // y <= clamp(rnd + d1)
    OP_LOAD   = 3'd2,  // acc <= rnd + d2
    OP_SUB    = 3'd3,  // acc <= acc - rnd
    OP_SWAP   = 3'd4,  // d1 <= sat(acc), acc <= rnd
    OP_FINISH = 3'd5,  // d2 <= sat(acc - rnd)
    OP_CLR    = 3'd6   // d1, d2, y <= 0
  } dp_op_e;

  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    dp_op_e   op;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/biq_cfg.sv
// Coefficient and output limit registers of the biquad filter.
// Depends on biq_pkg for the register index codes.
module biq_cfg #(
  parameter int SampleWidth = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int CoeffWidth  = biq_pkg::COEFF_WIDTH_DEF,
  localparam int CfgDw      = (SampleWidth > CoeffWidth) ? SampleWidth : CoeffWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [biq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CfgDw-1:0]                   cfg_data_i,
  output logic signed [CoeffWidth-1:0]       coef_b0_o,
  output logic signed [CoeffWidth-1:0]       coef_b1_o,
  output logic signed [CoeffWidth-1:0]       coef_b2_o,
  output logic signed [CoeffWidth-1:0]       coef_a1_o,
  output logic signed [CoeffWidth-1:0]       coef_a2_o,
  output logic signed [SampleWidth-1:0]      out_max_o,
  output logic signed [SampleWidth-1:0]      out_min_o
);

  localparam logic [CoeffWidth-1:0] B0Reset =
    CoeffWidth'(1) << (CoeffWidth - biq_pkg::COEFF_INT);
  localparam logic [SampleWidth-1:0] SMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic [SampleWidth-1:0] SMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic [CoeffWidth-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [SampleWidth-1:0] max_q, min_q;
  logic                   wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q  <= B0Reset;
      b1_q  <= '0;
      b2_q  <= '0;
      a1_q  <= '0;
      a2_q  <= '0;
      max_q <= SMax;
      min_q <= SMin;
    end else if (wr) begin
      unique case (biq_pkg::reg_idx_e'(cfg_index_i))
        biq_pkg::REG_B0:      b0_q  <= cfg_data_i[CoeffWidth-1:0];
        biq_pkg::REG_B1:      b1_q  <= cfg_data_i[CoeffWidth-1:0];
        biq_pkg::REG_B2:      b2_q  <= cfg_data_i[CoeffWidth-1:0];
        biq_pkg::REG_A1:      a1_q  <= cfg_data_i[CoeffWidth-1:0];
        biq_pkg::REG_A2:      a2_q  <= cfg_data_i[CoeffWidth-1:0];
        biq_pkg::REG_OUT_MAX: max_q <= cfg_data_i[SampleWidth-1:0];
        biq_pkg::REG_OUT_MIN: min_q <= cfg_data_i[SampleWidth-1:0];
        default: ;
      endcase
    end
  end

  assign coef_b0_o = signed'(b0_q);
  assign coef_b1_o = signed'(b1_q);
  assign coef_b2_o = signed'(b2_q);
  assign coef_a1_o = signed'(a1_q);
  assign coef_a2_o = signed'(a2_q);
  assign out_max_o = signed'(max_q);
  assign out_min_o = signed'(min_q);

endmodule

>>> rtl/core/biq_ctrl.sv
// Sequencer of the biquad filter: one state per multiply/accumulate step.
// Depends on biq_pkg for the command and status structs.
module biq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  output logic             in_ready_o,
  output biq_pkg::cmd_t    cmd_o,
  input  biq_pkg::status_t status_i
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_B0   = 9'b000000010,
    ST_Y    = 9'b000000100,
    ST_A1   = 9'b000001000,
    ST_B2   = 9'b000010000,
    ST_A2   = 9'b000100000,
    ST_D2   = 9'b001000000,
    ST_CLR  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.mul_sel  = biq_pkg::MUL_X_B0;
    cmd_o.op       = biq_pkg::OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = in_action_i ? ST_CLR : ST_B0;
        end
      end
      ST_B0: begin
        cmd_o.mul_sel = biq_pkg::MUL_X_B0;
        state_d       = ST_Y;
      end
      ST_Y: begin
        cmd_o.op      = biq_pkg::OP_Y;
        cmd_o.mul_sel = biq_pkg::MUL_X_B1;
        state_d       = ST_A1;
      end
      ST_A1: begin
        cmd_o.op      = biq_pkg::OP_LOAD;
        cmd_o.mul_sel = biq_pkg::MUL_Y_A1;
        state_d       = ST_B2;
      end
      ST_B2: begin
        cmd_o.op      = biq_pkg::OP_SUB;
        cmd_o.mul_sel = biq_pkg::MUL_X_B2;
        state_d       = ST_A2;
      end
      ST_A2: begin
        cmd_o.op      = biq_pkg::OP_SWAP;
        cmd_o.mul_sel = biq_pkg::MUL_Y_A2;
        state_d       = ST_D2;
      end
      ST_D2: begin
        cmd_o.op = biq_pkg::OP_FINISH;
        state_d  = ST_OUT;
      end
      ST_CLR: begin
        cmd_o.op = biq_pkg::OP_CLR;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/biq_dp.sv
// Datapath of the biquad filter: shared multiplier, rounding, accumulator,
// delays, clamp and the output register. Depends on biq_pkg.
module biq_dp #(
  parameter int SampleWidth = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int CoeffWidth  = biq_pkg::COEFF_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  biq_pkg::cmd_t                 cmd_i,
  output biq_pkg::status_t              status_o,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic signed [CoeffWidth-1:0]  coef_b0_i,
  input  logic signed [CoeffWidth-1:0]  coef_b1_i,
  input  logic signed [CoeffWidth-1:0]  coef_b2_i,
  input  logic signed [CoeffWidth-1:0]  coef_a1_i,
  input  logic signed [CoeffWidth-1:0]  coef_a2_i,
  input  logic signed [SampleWidth-1:0] out_max_i,
  input  logic signed [SampleWidth-1:0] out_min_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleWidth-1:0] out_data_o
);

  localparam int Pw = SampleWidth + CoeffWidth;
  localparam int Cf = CoeffWidth - biq_pkg::COEFF_INT;
  localparam int Rw = Pw - Cf;
  localparam int Yw = Rw + 1;
  localparam int Aw = Rw + 2;
  localparam logic [Pw-1:0] Half = Pw'(1) << (Cf - 1);
  localparam logic signed [SampleWidth-1:0] SMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic signed [SampleWidth-1:0] x_q, y_q, d1_q, d2_q, out_q;
  logic signed [SampleWidth-1:0] mul_a, y_clamp;
  logic signed [CoeffWidth-1:0]  mul_b;
  logic signed [Pw-1:0]          prod_q, prod_d, rnd_full;
  logic signed [Rw-1:0]          rnd;
  logic signed [Yw-1:0]          ysum;
  logic signed [Aw-1:0]          acc_q, diff;
  logic                          out_valid_q;

  function automatic logic signed [SampleWidth-1:0] sat(input logic signed [Aw-1:0] v);
    logic signed [SampleWidth-1:0] r;
    if (v > Aw'(SMax)) begin
      r = SMax;
    end else if (v < Aw'(SMin)) begin
      r = SMin;
    end else begin
      r = v[SampleWidth-1:0];
    end
    return r;
  endfunction

  always_comb begin
    mul_a = x_q;
    mul_b = coef_b0_i;
    case (cmd_i.mul_sel)
      biq_pkg::MUL_X_B0: begin mul_a = x_q; mul_b = coef_b0_i; end
      biq_pkg::MUL_X_B1: begin mul_a = x_q; mul_b = coef_b1_i; end
      biq_pkg::MUL_Y_A1: begin mul_a = y_q; mul_b = coef_a1_i; end
      biq_pkg::MUL_X_B2: begin mul_a = x_q; mul_b = coef_b2_i; end
      biq_pkg::MUL_Y_A2: begin mul_a = y_q; mul_b = coef_a2_i; end
      default: ;
    endcase
  end

  assign prod_d   = Pw'(mul_a) * Pw'(mul_b);
  // round half up, then drop the fractional coefficient bits
  assign rnd_full = prod_q + signed'(Half);
  assign rnd      = signed'(rnd_full[Pw-1:Cf]);
  assign ysum     = Yw'(rnd) + Yw'(d1_q);
  assign diff     = acc_q - Aw'(rnd);

  always_comb begin
    if (ysum > Yw'(out_max_i)) begin
      y_clamp = out_max_i;
    end else if (ysum < Yw'(out_min_i)) begin
      y_clamp = out_min_i;
    end else begin
      y_clamp = ysum[SampleWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.capture) begin
      x_q <= sample_i;
    end
    case (cmd_i.op)
      biq_pkg::OP_Y:    y_q   <= y_clamp;
      biq_pkg::OP_LOAD: acc_q <= Aw'(rnd) + Aw'(d2_q);
      biq_pkg::OP_SUB:  acc_q <= diff;
      biq_pkg::OP_SWAP: acc_q <= Aw'(rnd);
      biq_pkg::OP_CLR:  y_q   <= '0;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q <= y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      case (cmd_i.op)
        biq_pkg::OP_SWAP:   d1_q <= sat(acc_q);
        biq_pkg::OP_FINISH: d2_q <= sat(diff);
        biq_pkg::OP_CLR: begin
          d1_q <= '0;
          d2_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

>>> rtl/core/biquad_iir_saturated_top.sv
// Channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: sample_in; tuser: action
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: sample_out
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
// A clear word skips the filter's multiply steps; one product per cycle on the
// single shared multiplier. A finished word waits in the output register while
// the next input word is taken. Reset is asynchronous, active low; delays
// clear at once and the registers take their defaults. cfg is always ready.
// Top level of the biquad filter; uses biq_pkg, biq_cfg, biq_ctrl, biq_dp.
`include "biquad_iir_saturated_top_assert.svh"

module biquad_iir_saturated_top #(
  parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH  = biq_pkg::COEFF_WIDTH_DEF,
  localparam int CfgDw       = (SAMPLE_WIDTH > COEFF_WIDTH) ? SAMPLE_WIDTH : COEFF_WIDTH,
  localparam int TdataW      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [TdataW-1:0]             s_axis_tdata,  // sample_in
  input  logic                          s_axis_tuser,  // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [TdataW-1:0]             m_axis_tdata,  // sample_out
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CfgDw-1:0]              cfg_data_i
);

  logic signed [COEFF_WIDTH-1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_WIDTH-1:0] out_max, out_min, out_data;
  biq_pkg::cmd_t                  cmd;
  biq_pkg::status_t               status;

  biq_cfg #(
    .SampleWidth(SAMPLE_WIDTH),
    .CoeffWidth (COEFF_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .coef_b0_o  (coef_b0),
    .coef_b1_o  (coef_b1),
    .coef_b2_o  (coef_b2),
    .coef_a1_o  (coef_a1),
    .coef_a2_o  (coef_a2),
    .out_max_o  (out_max),
    .out_min_o  (out_min)
  );

  biq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_action_i(s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  biq_dp #(
    .SampleWidth(SAMPLE_WIDTH),
    .CoeffWidth (COEFF_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .sample_i   (signed'(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .coef_b0_i  (coef_b0),
    .coef_b1_i  (coef_b1),
    .coef_b2_i  (coef_b2),
    .coef_a1_i  (coef_a1),
    .coef_a2_i  (coef_a2),
    .out_max_i  (out_max),
    .out_min_i  (out_min),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = TdataW'($unsigned(out_data));

  `BIQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BIQ_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(m_axis_tvalid && !m_axis_tready))
  `BIQ_ASSERT_IMP(a_capture_on_accept, cmd.capture, s_axis_tvalid && s_axis_tready)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for biquad_iir_saturated_top. A transposed-DF-II model
// scores every output word; it uses Q4.28 coefficients, rounded products,
// saturating delays and the output clamp. Depends on biq_pkg and the filter RTL.

module testbench;

  localparam int SW          = biq_pkg::SAMPLE_WIDTH_DEF;
  localparam int CW          = biq_pkg::COEFF_WIDTH_DEF;
  localparam int DW          = (SW > CW) ? SW : CW;
  localparam int FRAC_C      = CW - biq_pkg::COEFF_INT;
  localparam int HALF_PERIOD = 5;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PIPE_CYCLES = 20;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 230;

  localparam logic [biq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic [SW-1:0] S_POS  = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_NEG  = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0] C_POS  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_NEG  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] C_ONE  = CW'(1) << FRAC_C;
  localparam logic [CW-1:0] C_HALF = CW'(1) << (FRAC_C - 1);
  localparam longint S_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [SW-1:0]                 s_axis_tdata  = '0;   // sample_in
  logic                          s_axis_tuser  = 1'b0; // action
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [SW-1:0]                 m_axis_tdata;         // sample_out
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DW-1:0]                 cfg_data_i    = '0;

  biquad_iir_saturated_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // filter state mirrored in the bench
  longint b0, b1, b2, a1, a2, y_max, y_min, dly1, dly2;
  logic [SW-1:0] sample_out_q[$];

  int   n_filt = 0, n_clear = 0, n_writes = 0, n_settings = 0, errors = 0;
  int   snd_idle_pct = 0, rcv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  function automatic longint rnd_product(longint s, longint c);
    longint p;
    p = s * c;
    return (p + (longint'(1) << (FRAC_C - 1))) >>> FRAC_C;
  endfunction

  function automatic longint sat_s(longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic logic [SW-1:0] biquad_out(logic act, logic [SW-1:0] x_bits);
    longint x, y, n1, n2;
    if (act == ACT_CLEAR) begin
      dly1 = 0;
      dly2 = 0;
      return '0;
    end
    x = longint'($signed(x_bits));
    y = rnd_product(x, b0) + dly1;
    if (y > y_max) y = y_max;
    else if (y < y_min) y = y_min;
    n1 = rnd_product(x, b1) + dly2 - rnd_product(y, a1);
    n2 = rnd_product(x, b2) - rnd_product(y, a2);
    dly1 = sat_s(n1);
    dly2 = sat_s(n2);
    return y[SW-1:0];
  endfunction

  function automatic logic [CW-1:0] pick_coef();
    logic [CW-1:0] c;
    case ($urandom_range(0, 9))
      0: return C_POS;
      1: return C_NEG;
      2: return '0;
      3, 4: return CW'($urandom);
      default: begin
        c = CW'($urandom_range(0, 1 << (FRAC_C - 1)));
        return $urandom_range(0, 1) ? -c : c;
      end
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] v;
    case ($urandom_range(0, 7))
      0: return S_POS;
      1: return S_NEG;
      2, 3: return SW'($urandom);
      default: begin
        v = SW'($urandom_range(0, 1 << 20));
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  task automatic send_word(logic act, logic [SW-1:0] x);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sample_out_q.push_back(biquad_out(act, x));
    if (act == ACT_CLEAR) n_clear++;
    else n_filt++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sample_out_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [biq_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      biq_pkg::REG_B0:      b0    = longint'($signed(val[CW-1:0]));
      biq_pkg::REG_B1:      b1    = longint'($signed(val[CW-1:0]));
      biq_pkg::REG_B2:      b2    = longint'($signed(val[CW-1:0]));
      biq_pkg::REG_A1:      a1    = longint'($signed(val[CW-1:0]));
      biq_pkg::REG_A2:      a2    = longint'($signed(val[CW-1:0]));
      biq_pkg::REG_OUT_MAX: y_max = longint'($signed(val[SW-1:0]));
      biq_pkg::REG_OUT_MIN: y_min = longint'($signed(val[SW-1:0]));
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_filter(logic [CW-1:0] c0, logic [CW-1:0] c1, logic [CW-1:0] c2,
                            logic [CW-1:0] f1, logic [CW-1:0] f2,
                            logic [SW-1:0] hi, logic [SW-1:0] lo);
    write_reg(biq_pkg::REG_B0, DW'(c0));
    write_reg(biq_pkg::REG_B1, DW'(c1));
    write_reg(biq_pkg::REG_B2, DW'(c2));
    write_reg(biq_pkg::REG_A1, DW'(f1));
    write_reg(biq_pkg::REG_A2, DW'(f2));
    write_reg(biq_pkg::REG_OUT_MAX, DW'(hi));
    write_reg(biq_pkg::REG_OUT_MIN, DW'(lo));
    n_settings++;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 45; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 45; end
      default: begin snd_idle_pct = 16; rcv_stall_pct = 16; end
    endcase
  endtask

  // reset defaults: unity b0, full-range clamp
  task automatic test_reset_values();
    set_idle(0);
    send_word(ACT_FILTER, S_POS);
    send_word(ACT_FILTER, S_NEG);
    send_word(ACT_FILTER, '0);
    send_word(ACT_FILTER, SW'(1));
    send_word(ACT_FILTER, '1);
    drain();
  endtask

  // ties round up, delays pin at the rails, clear zeroes them
  task automatic test_rounding_and_rails();
    set_filter(C_HALF, C_POS, C_NEG, C_NEG, C_POS, SW'(32'h0001_0000), -SW'(32'h0001_0000));
    send_word(ACT_FILTER, SW'(1));
    send_word(ACT_FILTER, '1);
    send_word(ACT_FILTER, S_POS);
    send_word(ACT_FILTER, S_NEG);
    send_word(ACT_CLEAR, S_POS);
    send_word(ACT_FILTER, '0);
    drain();
  endtask

  // out_max below out_min; a write past the last register changes nothing
  task automatic test_inverted_limits();
    set_filter(C_ONE, '0, '0, '0, '0, -SW'(32'h0001_0000), SW'(32'h0001_0000));
    write_reg(REG_UNUSED, DW'($urandom));
    send_word(ACT_FILTER, SW'(32'h0002_0000));
    send_word(ACT_FILTER, -SW'(32'h0002_0000));
    send_word(ACT_FILTER, '0);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [SW-1:0] hi, lo, t;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      hi = SW'($urandom);
      lo = SW'($urandom);
      case ($urandom_range(0, 5))
        0: begin hi = S_POS; lo = S_NEG; end
        1: if ($signed(hi) < $signed(lo)) begin t = hi; hi = lo; lo = t; end
        2: if ($signed(hi) > $signed(lo)) begin t = hi; hi = lo; lo = t; end
        default: begin
          hi = SW'($urandom_range(0, 1 << 22));
          lo = -SW'($urandom_range(0, 1 << 22));
        end
      endcase
      set_filter(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(), hi, lo);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, DW'($urandom));
      set_idle(ph % 4);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word(($urandom_range(0, 99) < 4) ? ACT_CLEAR : ACT_FILTER, pick_sample());
      drain();
    end
    set_idle(0);
  endtask

  // sink stalls for a long stretch while the source keeps offering words
  task automatic test_backpressure();
    set_filter(C_ONE, C_HALF, -C_HALF, pick_coef(), '0, S_POS, S_NEG);
    set_idle(0);
    @(posedge clk_i);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_word(ACT_FILTER, pick_sample());
    drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : out_check
    logic [SW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_out_q.size() == 0) begin
        errors++;
        $display("%0t: output word %h with none pending", $time, m_axis_tdata);
      end else begin
        want = sample_out_q.pop_front();
        if (m_axis_tdata !== want) begin
          errors++;
          $display("%0t: sample_out expected %h actual %h", $time, want, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    b0    = longint'($signed(C_ONE));
    b1    = 0;
    b2    = 0;
    a1    = 0;
    a2    = 0;
    y_max = S_MAX;
    y_min = S_MIN;
    dly1  = 0;
    dly2  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_rounding_and_rails();
    test_inverted_limits();
    test_backpressure();
    test_random_traffic();
    drain();

    $display("Ran %0d filter words and %0d clears through %0d filter settings",
             n_filt, n_clear, n_settings);
    $display("(%0d register writes), under four idle/stall mixes and a long sink stall.",
             n_writes);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
